### sv/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define BSUV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// condition must never be seen out of reset
`define BSUV_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define BSUV_ASSERT(lbl, prop, msg)
`define BSUV_NEVER(lbl, cond, msg)
`endif
`endif

### sv/bsuv_pkg.sv
// Shared types and constants of the box surface uv mapper.
package bsuv_pkg;

	localparam int FRAC_BITS_DEF = 16;

	typedef enum logic [2:0] {
		FACE_PX = 3'd0,
		FACE_NX = 3'd1,
		FACE_PY = 3'd2,
		FACE_NY = 3'd3,
		FACE_PZ = 3'd4,
		FACE_NZ = 3'd5
	} face_t;

	// outcome of one normalisation
	typedef enum logic [1:0] {
		UC_DIV  = 2'd0,
		UC_ZERO = 2'd1,
		UC_ONE  = 2'd2
	} ucode_t;

	localparam logic [2:0] REG_MID_X  = 3'd0;
	localparam logic [2:0] REG_MID_Y  = 3'd1;
	localparam logic [2:0] REG_MID_Z  = 3'd2;
	localparam logic [2:0] REG_SIZE_X = 3'd3;
	localparam logic [2:0] REG_SIZE_Y = 3'd4;
	localparam logic [2:0] REG_SIZE_Z = 3'd5;

	localparam logic [30:0] SIZE_RESET = 31'd65536;

endpackage

### sv/box_surface_uv_mapper_unit.sv
// Box surface uv mapper: point <-> (u, v) on the six faces of a configured box.
// Stages in order: local coords, face pick, one quotient bit per stage in two
// restoring dividers, output register.
// Throughput one request per cycle unless out_ready is low; a stalled output only
// halts the stages behind it, bubbles are squeezed out. Reset (arst_n low) clears
// all valid bits and puts the box at middle 0 with size 1.0 on each axis.
`include "assert_macros.svh"
module box_surface_uv_mapper_unit
	import bsuv_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// APB configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [4:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// request channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        func,
	input  logic signed [31:0]          pos_x,
	input  logic signed [31:0]          pos_y,
	input  logic signed [31:0]          pos_z,
	input  logic [FRAC_BITS+2:0]        param_u,
	input  logic [FRAC_BITS:0]          param_v,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [FRAC_BITS+2:0]        res_u,
	output logic [FRAC_BITS:0]          res_v,
	output logic signed [31:0]          res_x,
	output logic signed [31:0]          res_y,
	output logic signed [31:0]          res_z,
	output logic [2:0]                  face_index
);

	localparam int F  = FRAC_BITS;
	localparam int KW = F + 4;       // signed in-face scale factor
	localparam int PW = KW + 32;     // scale times size
	localparam int NS = F + 3;       // s1, s2, F divider stages, output

	localparam logic signed [KW-1:0] ONE_K = {{(KW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
	localparam logic signed [35:0]   SAT_HI = 36'sd2147483647;
	localparam logic signed [35:0]   SAT_LO = -36'sd2147483648;

	typedef struct packed {
		logic               fwd;
		logic signed [33:0] lx;
		logic signed [33:0] ly;
		logic signed [33:0] lz;
		face_t              rface;
		logic signed [KW-1:0] ks;
		logic signed [KW-1:0] kt;
	} s1_t;

	typedef struct packed {
		logic               fwd;
		face_t              face;
		logic signed [35:0] na;
		logic signed [35:0] nb;
		logic [31:0]        dena;
		logic [31:0]        denb;
		logic signed [KW-1:0] kx;
		logic signed [KW-1:0] ky;
		logic signed [KW-1:0] kz;
	} s2_t;

	typedef struct packed {
		logic               fwd;
		face_t              face;
		ucode_t             ca;
		ucode_t             cb;
		logic [31:0]        ra;
		logic [31:0]        rb;
		logic [31:0]        dena;
		logic [31:0]        denb;
		logic [F-1:0]       qa;
		logic [F-1:0]       qb;
		logic signed [PW-1:0] px;
		logic signed [PW-1:0] py;
		logic signed [PW-1:0] pz;
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] rz;
	} dv_t;

	typedef struct packed {
		logic [F+2:0]       u;
		logic [F:0]         v;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		face_t              face;
	} res_t;

	// ---------------- configuration registers ----------------
	logic signed [31:0] mid_x_q, mid_y_q, mid_z_q;
	logic [30:0]        size_x_q, size_y_q, size_z_q;
	logic [2:0]         reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_x_q  <= '0;
			mid_y_q  <= '0;
			mid_z_q  <= '0;
			size_x_q <= SIZE_RESET;
			size_y_q <= SIZE_RESET;
			size_z_q <= SIZE_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_MID_X:  mid_x_q  <= pwdata;
				REG_MID_Y:  mid_y_q  <= pwdata;
				REG_MID_Z:  mid_z_q  <= pwdata;
				REG_SIZE_X: size_x_q <= pwdata[30:0];
				REG_SIZE_Y: size_y_q <= pwdata[30:0];
				REG_SIZE_Z: size_z_q <= pwdata[30:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MID_X:  prdata = mid_x_q;
			REG_MID_Y:  prdata = mid_y_q;
			REG_MID_Z:  prdata = mid_z_q;
			REG_SIZE_X: prdata = {1'b0, size_x_q};
			REG_SIZE_Y: prdata = {1'b0, size_y_q};
			REG_SIZE_Z: prdata = {1'b0, size_z_q};
			default:    prdata = '0;
		endcase
	end

	// ---------------- flow control ----------------
	// a stage moves when it is empty or the one after it moves
	logic [NS-1:0] vld_s;
	logic [NS-1:0] en;

	always_comb begin
		en[NS-1] = !vld_s[NS-1] || out_ready;
		for (int i = NS - 2; i >= 0; i--) begin
			en[i] = !vld_s[i] || en[i+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_s[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) vld_s[0] <= in_valid;
			for (int i = 1; i < NS; i++) begin
				if (en[i]) vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// ---------------- stage 1: local coordinates, reverse face ----------------
	s1_t st_s1, s1_nx;
	logic [2:0] fl;

	always_comb begin
		fl          = param_u[F+2:F];
		s1_nx.fwd   = !func;
		s1_nx.lx    = {{2{pos_x[31]}}, pos_x} - {{2{mid_x_q[31]}}, mid_x_q};
		s1_nx.ly    = {{2{pos_y[31]}}, pos_y} - {{2{mid_y_q[31]}}, mid_y_q};
		s1_nx.lz    = {{2{pos_z[31]}}, pos_z} - {{2{mid_z_q[31]}}, mid_z_q};
		s1_nx.rface = (fl > 3'(FACE_NZ)) ? FACE_NZ : face_t'(fl);
		s1_nx.ks    = $signed({{(KW-F-1){1'b0}}, param_u[F-1:0], 1'b0}) - ONE_K;
		s1_nx.kt    = $signed({{(KW-F-2){1'b0}}, param_v, 1'b0}) - ONE_K;
	end

	always_ff @(posedge clk) begin
		if (en[0]) st_s1 <= s1_nx;
	end

	// ---------------- stage 2: nearest face, numerators, scale factors ----------------
	s2_t st_s2, s2_nx;
	logic signed [35:0] sx36, sy36, sz36;
	logic signed [35:0] lx36, ly36, lz36;
	logic signed [35:0] ax, ay, az, dx, dy, dz;
	logic signed [35:0] px_n, mx_n, py_n, my_n, pz_n;

	always_comb begin
		sx36 = $signed({5'b0, size_x_q});
		sy36 = $signed({5'b0, size_y_q});
		sz36 = $signed({5'b0, size_z_q});
		lx36 = {{2{st_s1.lx[33]}}, st_s1.lx};
		ly36 = {{2{st_s1.ly[33]}}, st_s1.ly};
		lz36 = {{2{st_s1.lz[33]}}, st_s1.lz};
		ax   = lx36[35] ? -lx36 : lx36;
		ay   = ly36[35] ? -ly36 : ly36;
		az   = lz36[35] ? -lz36 : lz36;
		dx   = (ax <<< 1) - sx36;
		dy   = (ay <<< 1) - sy36;
		dz   = (az <<< 1) - sz36;
		dx   = dx[35] ? -dx : dx;
		dy   = dy[35] ? -dy : dy;
		dz   = dz[35] ? -dz : dz;
		px_n = (lx36 <<< 1) + sx36;
		mx_n = sx36 - (lx36 <<< 1);
		py_n = (ly36 <<< 1) + sy36;
		my_n = sy36 - (ly36 <<< 1);
		pz_n = (lz36 <<< 1) + sz36;

		s2_nx.fwd = st_s1.fwd;
		s2_nx.kx  = st_s1.ks;
		s2_nx.ky  = st_s1.kt;
		s2_nx.kz  = ONE_K;
		if (st_s1.fwd) begin
			if (dx <= dy && dx <= dz) begin
				s2_nx.nb   = pz_n;
				s2_nx.denb = {size_z_q, 1'b0};
				s2_nx.dena = {size_y_q, 1'b0};
				if (!lx36[35]) begin
					s2_nx.face = FACE_PX;
					s2_nx.na   = py_n;
				end else begin
					s2_nx.face = FACE_NX;
					s2_nx.na   = my_n;
				end
			end else if (dy <= dz) begin
				s2_nx.nb   = pz_n;
				s2_nx.denb = {size_z_q, 1'b0};
				s2_nx.dena = {size_x_q, 1'b0};
				if (!ly36[35]) begin
					s2_nx.face = FACE_PY;
					s2_nx.na   = mx_n;
				end else begin
					s2_nx.face = FACE_NY;
					s2_nx.na   = px_n;
				end
			end else begin
				s2_nx.na   = px_n;
				s2_nx.dena = {size_x_q, 1'b0};
				s2_nx.denb = {size_y_q, 1'b0};
				if (!lz36[35]) begin
					s2_nx.face = FACE_PZ;
					s2_nx.nb   = py_n;
				end else begin
					s2_nx.face = FACE_NZ;
					s2_nx.nb   = my_n;
				end
			end
		end else begin
			s2_nx.face = st_s1.rface;
			s2_nx.na   = '0;
			s2_nx.nb   = '0;
			s2_nx.dena = {size_x_q, 1'b0};
			s2_nx.denb = {size_y_q, 1'b0};
			case (st_s1.rface)
				FACE_PX: begin
					s2_nx.kx = ONE_K;     s2_nx.ky = st_s1.ks;  s2_nx.kz = st_s1.kt;
				end
				FACE_NX: begin
					s2_nx.kx = -ONE_K;    s2_nx.ky = -st_s1.ks; s2_nx.kz = st_s1.kt;
				end
				FACE_PY: begin
					s2_nx.kx = -st_s1.ks; s2_nx.ky = ONE_K;     s2_nx.kz = st_s1.kt;
				end
				FACE_NY: begin
					s2_nx.kx = st_s1.ks;  s2_nx.ky = -ONE_K;    s2_nx.kz = st_s1.kt;
				end
				FACE_PZ: begin
					s2_nx.kx = st_s1.ks;  s2_nx.ky = st_s1.kt;  s2_nx.kz = ONE_K;
				end
				default: begin
					s2_nx.kx = st_s1.ks;  s2_nx.ky = -st_s1.kt; s2_nx.kz = -ONE_K;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) st_s2 <= s2_nx;
	end

	// ---------------- divider stages: one quotient bit each ----------------
	// reverse path rides along: product in the first, offset and saturation in the second
	dv_t dv_s  [F];
	dv_t dv_nx [F];

	for (genvar k = 0; k < F; k++) begin : g_div
		dv_t        src;
		logic [32:0] ra2, rb2;
		logic        gea, geb;
		logic signed [35:0] sum_x, sum_y, sum_z;

		always_comb begin
			if (k == 0) begin
				src.fwd  = st_s2.fwd;
				src.face = st_s2.face;
				src.dena = st_s2.dena;
				src.denb = st_s2.denb;
				src.ca   = (st_s2.na <= 36'sd0) ? UC_ZERO :
				           (st_s2.na >= $signed({4'b0, st_s2.dena})) ? UC_ONE : UC_DIV;
				src.cb   = (st_s2.nb <= 36'sd0) ? UC_ZERO :
				           (st_s2.nb >= $signed({4'b0, st_s2.denb})) ? UC_ONE : UC_DIV;
				src.ra   = st_s2.na[31:0];
				src.rb   = st_s2.nb[31:0];
				src.qa   = '0;
				src.qb   = '0;
				src.px   = PW'(st_s2.kx) * $signed({1'b0, size_x_q});
				src.py   = PW'(st_s2.ky) * $signed({1'b0, size_y_q});
				src.pz   = PW'(st_s2.kz) * $signed({1'b0, size_z_q});
				src.rx   = '0;
				src.ry   = '0;
				src.rz   = '0;
			end else begin
				src = dv_s[k-1];
			end

			ra2 = {src.ra, 1'b0};
			rb2 = {src.rb, 1'b0};
			gea = ra2 >= {1'b0, src.dena};
			geb = rb2 >= {1'b0, src.denb};
			dv_nx[k]    = src;
			dv_nx[k].ra = gea ? 32'(ra2 - {1'b0, src.dena}) : ra2[31:0];
			dv_nx[k].rb = geb ? 32'(rb2 - {1'b0, src.denb}) : rb2[31:0];
			dv_nx[k].qa = {src.qa[F-2:0], gea};
			dv_nx[k].qb = {src.qb[F-2:0], geb};

			// floor(k*size / 2one) is an arithmetic shift
			sum_x = {{4{mid_x_q[31]}}, mid_x_q} + 36'(src.px >>> (F + 1));
			sum_y = {{4{mid_y_q[31]}}, mid_y_q} + 36'(src.py >>> (F + 1));
			sum_z = {{4{mid_z_q[31]}}, mid_z_q} + 36'(src.pz >>> (F + 1));
			if (k == 1 && !src.fwd) begin
				dv_nx[k].rx = (sum_x > SAT_HI) ? 32'(SAT_HI) :
				              (sum_x < SAT_LO) ? 32'(SAT_LO) : sum_x[31:0];
				dv_nx[k].ry = (sum_y > SAT_HI) ? 32'(SAT_HI) :
				              (sum_y < SAT_LO) ? 32'(SAT_LO) : sum_y[31:0];
				dv_nx[k].rz = (sum_z > SAT_HI) ? 32'(SAT_HI) :
				              (sum_z < SAT_LO) ? 32'(SAT_LO) : sum_z[31:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k+2]) dv_s[k] <= dv_nx[k];
		end
	end

	// ---------------- output register ----------------
	res_t res_s, res_nx;
	dv_t  lst;
	logic [F+2:0] a_val;
	logic [F:0]   b_val;

	always_comb begin
		lst   = dv_s[F-1];
		a_val = (lst.ca == UC_ONE)  ? (F+3)'(ONE_K) :
		        (lst.ca == UC_ZERO) ? '0 : {3'b0, lst.qa};
		b_val = (lst.cb == UC_ONE)  ? (F+1)'(ONE_K) :
		        (lst.cb == UC_ZERO) ? '0 : {1'b0, lst.qb};
		res_nx.face = lst.face;
		if (lst.fwd) begin
			res_nx.u = {lst.face, {F{1'b0}}} + a_val;
			res_nx.v = b_val;
			res_nx.x = '0;
			res_nx.y = '0;
			res_nx.z = '0;
		end else begin
			res_nx.u = '0;
			res_nx.v = '0;
			res_nx.x = lst.rx;
			res_nx.y = lst.ry;
			res_nx.z = lst.rz;
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) res_s <= res_nx;
	end

	assign res_u      = res_s.u;
	assign res_v      = res_s.v;
	assign res_x      = res_s.x;
	assign res_y      = res_s.y;
	assign res_z      = res_s.z;
	assign face_index = res_s.face;

	// ---------------- checks ----------------
	`BSUV_ASSERT(a_face_range, out_valid |-> face_index <= 3'(FACE_NZ), "face out of range")
	`BSUV_ASSERT(a_v_unit, out_valid |-> res_v <= (F+1)'(ONE_K), "normalised v above one")
	`BSUV_NEVER(a_mode_mix, out_valid && |{res_u, res_v} && |{res_x, res_y, res_z}, "mixed")

endmodule
